// File: hw/rtl/imhdk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imhdk_pkg
// Shared types and codes for the indexed min-heap with decrease-to-half.
// ----------------------------------------------------------------------------
package imhdk_pkg;

   localparam int KEY_W  = 10;
   localparam int CAP_W  = 9;
   localparam int STAT_W = 3;
   localparam int CMD_W  = 2;
   localparam int OP_W   = 5;

   // request commands
   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REDUCE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
   localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd3;

   // response status
   localparam logic [STAT_W-1:0] ST_OK     = 3'd0;
   localparam logic [STAT_W-1:0] ST_FULL   = 3'd1;
   localparam logic [STAT_W-1:0] ST_EMPTY  = 3'd2;
   localparam logic [STAT_W-1:0] ST_RANGE  = 3'd3;
   localparam logic [STAT_W-1:0] ST_EXISTS = 3'd4;

   // csr indexes
   localparam logic CSR_CAPACITY = 1'b0;
   localparam logic CSR_MAX_KEY  = 1'b1;

   // datapath operations
   localparam logic [OP_W-1:0] OP_NONE   = 5'd0;
   localparam logic [OP_W-1:0] OP_CLEAR  = 5'd1;
   localparam logic [OP_W-1:0] OP_ACCEPT = 5'd2;
   localparam logic [OP_W-1:0] OP_RDHALF = 5'd3;
   localparam logic [OP_W-1:0] OP_CHECK  = 5'd4;
   localparam logic [OP_W-1:0] OP_INS    = 5'd5;
   localparam logic [OP_W-1:0] OP_REDSET = 5'd6;
   localparam logic [OP_W-1:0] OP_REDTAG = 5'd7;
   localparam logic [OP_W-1:0] OP_REMSET = 5'd8;
   localparam logic [OP_W-1:0] OP_REMUNM = 5'd9;
   localparam logic [OP_W-1:0] OP_REMLST = 5'd10;
   localparam logic [OP_W-1:0] OP_UPRD   = 5'd11;
   localparam logic [OP_W-1:0] OP_UPCMP  = 5'd12;
   localparam logic [OP_W-1:0] OP_DNRDL  = 5'd13;
   localparam logic [OP_W-1:0] OP_DNRDR  = 5'd14;
   localparam logic [OP_W-1:0] OP_DNCMP  = 5'd15;
   localparam logic [OP_W-1:0] OP_PLACE  = 5'd16;
   localparam logic [OP_W-1:0] OP_FINRD  = 5'd17;
   localparam logic [OP_W-1:0] OP_FIN    = 5'd18;

   typedef struct packed {
      logic [OP_W-1:0] op;
   } dp_cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             ok;
      logic             is_top;
      logic             is_leaf;
      logic             swap_up;
      logic             swap_dn;
      logic             last_one;
      logic             clr_last;
      logic             out_busy;
   } dp_status_type;

endpackage

// File: hw/rtl/imhdk_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imhdk_ctrl
// Sequencer: map clearing, checks, sift up and sift down walks, response.
// ----------------------------------------------------------------------------
module imhdk_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  imhdk_pkg::dp_status_type sts,
   output imhdk_pkg::dp_cmd_type   dpc
);
   import imhdk_pkg::*;

   localparam logic [4:0] S_CLEAR  = 5'd0;
   localparam logic [4:0] S_IDLE   = 5'd1;
   localparam logic [4:0] S_RDHALF = 5'd2;
   localparam logic [4:0] S_CHECK  = 5'd3;
   localparam logic [4:0] S_INS    = 5'd4;
   localparam logic [4:0] S_REDSET = 5'd5;
   localparam logic [4:0] S_REDTAG = 5'd6;
   localparam logic [4:0] S_REMSET = 5'd7;
   localparam logic [4:0] S_REMUNM = 5'd8;
   localparam logic [4:0] S_REMLST = 5'd9;
   localparam logic [4:0] S_UPTEST = 5'd10;
   localparam logic [4:0] S_UPRD   = 5'd11;
   localparam logic [4:0] S_UPCMP  = 5'd12;
   localparam logic [4:0] S_DNTEST = 5'd13;
   localparam logic [4:0] S_DNRDL  = 5'd14;
   localparam logic [4:0] S_DNRDR  = 5'd15;
   localparam logic [4:0] S_DNCMP  = 5'd16;
   localparam logic [4:0] S_PLACE  = 5'd17;
   localparam logic [4:0] S_FINRD  = 5'd18;
   localparam logic [4:0] S_FIN    = 5'd19;

   logic [4:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      dpc.op    = OP_NONE;
      req_stall = 1'b1;
      case (state_ff)
         S_CLEAR: begin
            dpc.op = OP_CLEAR;
            if (sts.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               dpc.op   = OP_ACCEPT;
               state_in = S_RDHALF;
            end
         end
         S_RDHALF: begin
            dpc.op   = OP_RDHALF;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            dpc.op = OP_CHECK;
            if (!sts.ok) state_in = S_FINRD;
            else begin
               case (sts.cmd)
                  CMD_INSERT: state_in = S_INS;
                  CMD_REDUCE: state_in = S_REDSET;
                  CMD_REMOVE: state_in = S_REMSET;
                  default:    state_in = S_FINRD;
               endcase
            end
         end
         S_INS: begin
            dpc.op   = OP_INS;
            state_in = S_UPTEST;
         end
         S_REDSET: begin
            dpc.op   = OP_REDSET;
            state_in = S_REDTAG;
         end
         S_REDTAG: begin
            dpc.op   = OP_REDTAG;
            state_in = S_UPTEST;
         end
         S_REMSET: begin
            dpc.op   = OP_REMSET;
            state_in = S_REMUNM;
         end
         S_REMUNM: begin
            dpc.op   = OP_REMUNM;
            state_in = S_REMLST;
         end
         S_REMLST: begin
            dpc.op   = OP_REMLST;
            state_in = sts.last_one ? S_FINRD : S_DNTEST;
         end
         S_UPTEST: begin
            state_in = sts.is_top ? S_PLACE : S_UPRD;
         end
         S_UPRD: begin
            dpc.op   = OP_UPRD;
            state_in = S_UPCMP;
         end
         S_UPCMP: begin
            dpc.op   = OP_UPCMP;
            state_in = sts.swap_up ? S_UPTEST : S_PLACE;
         end
         S_DNTEST: begin
            state_in = sts.is_leaf ? S_PLACE : S_DNRDL;
         end
         S_DNRDL: begin
            dpc.op   = OP_DNRDL;
            state_in = S_DNRDR;
         end
         S_DNRDR: begin
            dpc.op   = OP_DNRDR;
            state_in = S_DNCMP;
         end
         S_DNCMP: begin
            dpc.op   = OP_DNCMP;
            state_in = sts.swap_dn ? S_DNTEST : S_PLACE;
         end
         S_PLACE: begin
            dpc.op   = OP_PLACE;
            state_in = S_FINRD;
         end
         S_FINRD: begin
            dpc.op   = OP_FINRD;
            state_in = S_FIN;
         end
         S_FIN: begin
            if (!sts.out_busy) begin
               dpc.op   = OP_FIN;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_CLEAR;
      else       state_ff <= state_in;
   end

endmodule

// File: hw/rtl/imhdk_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imhdk_datapath
// Slot memory, key-to-slot map, moving entry, counters and response register.
// ----------------------------------------------------------------------------
module imhdk_datapath #(
   parameter int HEAP_DEPTH = 256,
   parameter int KEY_SPACE  = 1024,
   parameter int TAG_BITS   = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  imhdk_pkg::dp_cmd_type         dpc,
   output imhdk_pkg::dp_status_type      sts,
   input  logic [imhdk_pkg::CMD_W-1:0]   req_command,
   input  logic [imhdk_pkg::KEY_W-1:0]   req_key,
   input  logic [TAG_BITS-1:0]           req_payload_tag,
   input  logic                          csr_valid,
   input  logic                          csr_index,
   input  logic [imhdk_pkg::KEY_W-1:0]   csr_wdata,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [imhdk_pkg::STAT_W-1:0]  rsp_status,
   output logic                          rsp_key_present,
   output logic [imhdk_pkg::KEY_W-1:0]   rsp_min_key,
   output logic [TAG_BITS-1:0]           rsp_min_payload,
   output logic [imhdk_pkg::CAP_W-1:0]   rsp_entry_count
);
   import imhdk_pkg::*;

   localparam int SLOT_W = $clog2(HEAP_DEPTH + 1);
   localparam int MAP_W  = $clog2(KEY_SPACE);
   localparam int ENT_W  = KEY_W + TAG_BITS;

   logic [ENT_W-1:0]  slot_mem [0:HEAP_DEPTH];
   logic [SLOT_W-1:0] map_mem  [0:KEY_SPACE-1];

   logic [CMD_W-1:0]    cmd_ff;
   logic [KEY_W-1:0]    key_ff, mk_ff;
   logic [TAG_BITS-1:0] tag_ff, mt_ff;
   logic [STAT_W-1:0]   st_ff, st_calc;
   logic [SLOT_W-1:0]   map_key_ff, count_ff, pos_ff, map_rd_ff;
   logic [ENT_W-1:0]    slot_rd_ff, left_ff, sel_ent;
   logic [MAP_W-1:0]    clr_ff;
   logic [CAP_W-1:0]    cap_ff;
   logic [KEY_W-1:0]    maxk_ff;
   logic                rsp_valid_ff;

   logic [SLOT_W-1:0] slot_raddr, slot_waddr, map_wdata, sel_idx;
   logic [ENT_W-1:0]  slot_wdata;
   logic              slot_we, map_we;
   logic [MAP_W-1:0]  map_raddr, map_waddr;
   logic [SLOT_W:0]   child;
   logic              in_range, full, has_right, use_r;
   logic [KEY_W-1:0]  rd_key, left_key, sel_key;

   assign rd_key   = slot_rd_ff[TAG_BITS +: KEY_W];
   assign left_key = left_ff[TAG_BITS +: KEY_W];
   assign in_range = (key_ff <= maxk_ff) && (32'(key_ff) < 32'(KEY_SPACE));
   assign full     = (32'(count_ff) >= 32'(cap_ff)) || (32'(count_ff) >= 32'(HEAP_DEPTH));
   assign child    = {pos_ff, 1'b0};
   assign has_right = child < {1'b0, count_ff};
   assign use_r    = has_right && (rd_key < left_key);
   assign sel_ent  = use_r ? slot_rd_ff : left_ff;
   assign sel_key  = sel_ent[TAG_BITS +: KEY_W];
   assign sel_idx  = use_r ? SLOT_W'(child) + SLOT_W'(1) : SLOT_W'(child);

   always_comb begin
      st_calc = ST_OK;
      case (cmd_ff)
         CMD_INSERT: begin
            if (!in_range)              st_calc = ST_RANGE;
            else if (full)              st_calc = ST_FULL;
            else if (map_key_ff != '0)  st_calc = ST_EXISTS;
         end
         CMD_REDUCE: begin
            if (!in_range) st_calc = ST_RANGE;
            else if (map_key_ff == '0 || map_rd_ff != '0) st_calc = ST_EXISTS;
         end
         CMD_REMOVE: begin
            if (count_ff == '0) st_calc = ST_EMPTY;
         end
         default: begin
            if (!in_range) st_calc = ST_RANGE;
         end
      endcase
   end

   always_comb begin
      sts.cmd      = cmd_ff;
      sts.ok       = (st_calc == ST_OK);
      sts.is_top   = (pos_ff == SLOT_W'(1));
      sts.is_leaf  = child > {1'b0, count_ff};
      sts.swap_up  = rd_key > mk_ff;
      sts.swap_dn  = sel_key < mk_ff;
      sts.last_one = (count_ff == SLOT_W'(1));
      sts.clr_last = (clr_ff == MAP_W'(KEY_SPACE - 1));
      sts.out_busy = rsp_valid_ff && rsp_stall;
   end

   // memory addressing
   always_comb begin
      slot_raddr = SLOT_W'(1);
      map_raddr  = MAP_W'(key_ff);
      slot_we    = 1'b0;
      slot_waddr = pos_ff;
      slot_wdata = {mk_ff, mt_ff};
      map_we     = 1'b0;
      map_waddr  = MAP_W'(mk_ff);
      map_wdata  = pos_ff;
      case (dpc.op)
         OP_CLEAR: begin
            map_we    = 1'b1;
            map_waddr = clr_ff;
            map_wdata = '0;
         end
         OP_ACCEPT: map_raddr = MAP_W'(req_key);
         OP_RDHALF: map_raddr = MAP_W'(key_ff >> 1);
         OP_REDSET: begin
            slot_raddr = map_key_ff;
            map_we     = 1'b1;
            map_waddr  = MAP_W'(key_ff);
            map_wdata  = '0;
         end
         OP_REMSET: slot_raddr = SLOT_W'(1);
         OP_REMUNM: begin
            slot_raddr = count_ff;
            map_we     = 1'b1;
            map_waddr  = MAP_W'(rd_key);
            map_wdata  = '0;
         end
         OP_UPRD:  slot_raddr = pos_ff >> 1;
         OP_UPCMP: begin
            slot_we    = sts.swap_up;
            slot_wdata = slot_rd_ff;
            map_we     = sts.swap_up;
            map_waddr  = MAP_W'(rd_key);
         end
         OP_DNRDL: slot_raddr = SLOT_W'(child);
         OP_DNRDR: slot_raddr = SLOT_W'(child) + SLOT_W'(1);
         OP_DNCMP: begin
            slot_we    = sts.swap_dn;
            slot_wdata = sel_ent;
            map_we     = sts.swap_dn;
            map_waddr  = MAP_W'(sel_key);
         end
         OP_PLACE: begin
            slot_we = 1'b1;
            map_we  = 1'b1;
         end
         OP_FINRD: begin
            slot_raddr = SLOT_W'(1);
            map_raddr  = MAP_W'(key_ff);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
      slot_rd_ff <= slot_mem[slot_raddr];
   end

   always_ff @(posedge clock) begin
      if (map_we) map_mem[map_waddr] <= map_wdata;
      map_rd_ff <= map_mem[map_raddr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         clr_ff       <= '0;
         cap_ff       <= 9'd256;
         maxk_ff      <= 10'd1023;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (dpc.op == OP_CLEAR)  clr_ff <= clr_ff + MAP_W'(1);
         if (dpc.op == OP_INS)    count_ff <= count_ff + SLOT_W'(1);
         if (dpc.op == OP_REMLST) count_ff <= count_ff - SLOT_W'(1);
         if (csr_valid) begin
            case (csr_index)
               CSR_CAPACITY: cap_ff  <= csr_wdata[CAP_W-1:0];
               CSR_MAX_KEY:  maxk_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (dpc.op == OP_FIN)  rsp_valid_ff <= 1'b1;
         else if (!rsp_stall)   rsp_valid_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      case (dpc.op)
         OP_ACCEPT: begin
            cmd_ff <= req_command;
            key_ff <= req_key;
            tag_ff <= req_payload_tag;
         end
         OP_RDHALF: map_key_ff <= map_rd_ff;
         OP_CHECK:  st_ff <= st_calc;
         OP_INS: begin
            pos_ff <= count_ff + SLOT_W'(1);
            mk_ff  <= key_ff;
            mt_ff  <= tag_ff;
         end
         OP_REDSET: pos_ff <= map_key_ff;
         OP_REDTAG: begin
            mk_ff <= key_ff >> 1;
            mt_ff <= slot_rd_ff[TAG_BITS-1:0];
         end
         OP_REMLST: begin
            pos_ff <= SLOT_W'(1);
            mk_ff  <= rd_key;
            mt_ff  <= slot_rd_ff[TAG_BITS-1:0];
         end
         OP_UPCMP: if (sts.swap_up) pos_ff <= pos_ff >> 1;
         OP_DNRDR: left_ff <= slot_rd_ff;
         OP_DNCMP: if (sts.swap_dn) pos_ff <= sel_idx;
         OP_FIN: begin
            rsp_status      <= st_ff;
            rsp_key_present <= in_range && (map_rd_ff != '0);
            rsp_min_key     <= (count_ff != '0) ? rd_key : '0;
            rsp_min_payload <= (count_ff != '0) ? slot_rd_ff[TAG_BITS-1:0] : '0;
            rsp_entry_count <= CAP_W'(count_ff);
         end
         default: ;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: hw/rtl/indexed_min_heap_decrease_key_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_min_heap_decrease_key_top
// Indexed binary min-heap: insert, reduce key to half, remove min, lookup.
//
//   channel  handshake          payload
//   req      req_valid/stall    command, key, payload_tag
//   rsp      rsp_valid/stall    status, key_present, min_key, min_payload,
//                               entry_count
//   csr      csr_valid/ready    csr_index, csr_wdata
//
// one request at a time; each sift-up level reads the parent, then compares,
// and each sift-down level reads the left child, then the right child, then
// compares, since the slot memory has a single read port
// after reset a clearing pass zeroes every entry of the key map
// a finished response waits in the output register while the next request
// is taken; it only blocks completion of that next request
// ----------------------------------------------------------------------------
module indexed_min_heap_decrease_key_top #(
   parameter int HEAP_DEPTH = 256,
   parameter int KEY_SPACE  = 1024,
   parameter int TAG_BITS   = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [imhdk_pkg::CMD_W-1:0]   req_command,
   input  logic [imhdk_pkg::KEY_W-1:0]   req_key,
   input  logic [TAG_BITS-1:0]           req_payload_tag,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [imhdk_pkg::STAT_W-1:0]  rsp_status,
   output logic                          rsp_key_present,
   output logic [imhdk_pkg::KEY_W-1:0]   rsp_min_key,
   output logic [TAG_BITS-1:0]           rsp_min_payload,
   output logic [imhdk_pkg::CAP_W-1:0]   rsp_entry_count,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_index,
   input  logic [imhdk_pkg::KEY_W-1:0]   csr_wdata
);
   import imhdk_pkg::*;

   dp_cmd_type    dpc;
   dp_status_type sts;

   assign csr_ready = 1'b1;

   imhdk_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .dpc       (dpc)
   );

   imhdk_datapath #(
      .HEAP_DEPTH (HEAP_DEPTH),
      .KEY_SPACE  (KEY_SPACE),
      .TAG_BITS   (TAG_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .dpc             (dpc),
      .sts             (sts),
      .req_command     (req_command),
      .req_key         (req_key),
      .req_payload_tag (req_payload_tag),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_key_present (rsp_key_present),
      .rsp_min_key     (rsp_min_key),
      .rsp_min_payload (rsp_min_payload),
      .rsp_entry_count (rsp_entry_count)
   );

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the indexed min-heap: a scoreboard class keeps its
// own heap and key map, predicts every response and compares it field by
// field; stimulus mixes directed corner cases, random command streams and
// several capacity / key-limit settings, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb;
   import imhdk_pkg::*;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic              present;
      logic [KEY_W-1:0]  min_key;
      logic [15:0]       min_tag;
      logic [CAP_W-1:0]  count;
   } heap_rsp_type;

   class heap_scoreboard;
      logic [KEY_W-1:0] keys [1:256];
      logic [15:0]      tags [1:256];
      int unsigned      slot_of [0:1023];
      int unsigned      count;
      int unsigned      capacity;
      int unsigned      max_key;
      heap_rsp_type     pending [$];
      int               errors;

      function new();
         foreach (slot_of[i]) slot_of[i] = 0;
         count = 0;
         capacity = 256;
         max_key = 1023;
         errors = 0;
      endfunction

      function bit in_range(int unsigned k);
         return k <= max_key;
      endfunction

      function void place(int unsigned s, logic [KEY_W-1:0] k, logic [15:0] t);
         keys[s] = k;
         tags[s] = t;
         slot_of[k] = s;
      endfunction

      function void swap_slots(int unsigned a, int unsigned b);
         logic [KEY_W-1:0] k;
         logic [15:0]      t;
         k = keys[a];
         t = tags[a];
         place(a, keys[b], tags[b]);
         place(b, k, t);
      endfunction

      function void bubble_up(int unsigned p);
         while (p > 1 && keys[p / 2] > keys[p]) begin
            swap_slots(p, p / 2);
            p = p / 2;
         end
      endfunction

      function void bubble_down(int unsigned p);
         int unsigned c;
         forever begin
            c = p * 2;
            if (c > count) break;
            if (c + 1 <= count && keys[c + 1] < keys[c]) c++;
            if (keys[c] >= keys[p]) break;
            swap_slots(p, c);
            p = c;
         end
      endfunction

      function void write_reg(logic idx, logic [KEY_W-1:0] val);
         if (idx == CSR_CAPACITY) capacity = val[CAP_W-1:0];
         else max_key = val;
      endfunction

      function void note_request(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                                 logic [15:0] tag);
         heap_rsp_type r;
         int unsigned cap, p;
         cap = capacity < 256 ? capacity : 256;
         r.status = ST_OK;
         case (cmd)
            CMD_INSERT: begin
               if (!in_range(key)) r.status = ST_RANGE;
               else if (count >= cap) r.status = ST_FULL;
               else if (slot_of[key] != 0) r.status = ST_EXISTS;
               else begin
                  count++;
                  place(count, key, tag);
                  bubble_up(count);
               end
            end
            CMD_REDUCE: begin
               if (!in_range(key)) r.status = ST_RANGE;
               else if (slot_of[key] == 0 || slot_of[key / 2] != 0) r.status = ST_EXISTS;
               else begin
                  p = slot_of[key];
                  slot_of[key] = 0;
                  place(p, key / 2, tags[p]);
                  bubble_up(p);
               end
            end
            CMD_REMOVE: begin
               if (count == 0) r.status = ST_EMPTY;
               else begin
                  slot_of[keys[1]] = 0;
                  if (count > 1) place(1, keys[count], tags[count]);
                  count--;
                  bubble_down(1);
               end
            end
            default: begin
               if (!in_range(key)) r.status = ST_RANGE;
            end
         endcase
         r.present = in_range(key) && slot_of[key] != 0;
         r.min_key = count ? keys[1] : '0;
         r.min_tag = count ? tags[1] : '0;
         r.count   = CAP_W'(count);
         pending.push_back(r);
      endfunction

      function void check_response(heap_rsp_type got);
         heap_rsp_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected response %p", $time, got);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.status !== e.status) begin
            $display("%0t: status exp %0d got %0d", $time, e.status, got.status);
            errors++;
         end
         if (got.present !== e.present) begin
            $display("%0t: key_present exp %0d got %0d", $time, e.present, got.present);
            errors++;
         end
         if (got.min_key !== e.min_key) begin
            $display("%0t: min_key exp %0d got %0d", $time, e.min_key, got.min_key);
            errors++;
         end
         if (got.min_tag !== e.min_tag) begin
            $display("%0t: min_payload exp %0h got %0h", $time, e.min_tag, got.min_tag);
            errors++;
         end
         if (got.count !== e.count) begin
            $display("%0t: entry_count exp %0d got %0d", $time, e.count, got.count);
            errors++;
         end
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [CMD_W-1:0]    req_command;
   logic [KEY_W-1:0]    req_key;
   logic [15:0]         req_payload_tag;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [STAT_W-1:0]   rsp_status;
   logic                rsp_key_present;
   logic [KEY_W-1:0]    rsp_min_key;
   logic [15:0]         rsp_min_payload;
   logic [CAP_W-1:0]    rsp_entry_count;
   logic                csr_valid;
   logic                csr_ready;
   logic                csr_index;
   logic [KEY_W-1:0]    csr_wdata;

   heap_scoreboard sb;
   bit             quiet;
   int unsigned    live_keys [$];

   indexed_min_heap_decrease_key_top dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("tb: FAIL");
      $finish;
   end

   // response side: random stall bursts
   initial begin
      int n;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (!quiet && $urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 19);
            rsp_stall = 1'b1;
            repeat (n) @(negedge clock);
            rsp_stall = 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response({rsp_status, rsp_key_present, rsp_min_key,
                            rsp_min_payload, rsp_entry_count});
   end

   task automatic send_request(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                               logic [15:0] tag);
      int n;
      if (!quiet && $urandom_range(0, 7) == 0) begin
         n = $urandom_range(1, 19);
         repeat (n) @(negedge clock);
      end
      req_valid = 1'b1;
      req_command = cmd;
      req_key = key;
      req_payload_tag = tag;
      do @(posedge clock); while (req_stall);
      sb.note_request(cmd, key, tag);
      if (cmd == CMD_INSERT) live_keys.push_back(key);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic drain();
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_csr(logic idx, logic [KEY_W-1:0] val);
      drain();
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, val);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic random_run(int n, int unsigned kmax);
      int unsigned c, k;
      repeat (n) begin
         c = $urandom_range(0, 9);
         if (c < 4) k = $urandom_range(0, kmax);
         else if (live_keys.size() != 0 && $urandom_range(0, 3) != 0)
            k = live_keys[$urandom_range(0, live_keys.size() - 1)];
         else k = $urandom_range(0, 1023);
         send_request(c < 4 ? CMD_INSERT : c < 6 ? CMD_REDUCE :
                      c < 8 ? CMD_REMOVE : CMD_LOOKUP, KEY_W'(k), 16'($urandom));
      end
   endtask

   initial begin
      sb = new();
      quiet = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_command = CMD_INSERT;
      req_key = '0;
      req_payload_tag = '0;
      csr_valid = 1'b0;
      csr_index = CSR_CAPACITY;
      csr_wdata = '0;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // directed corners
      send_request(CMD_REMOVE, 10'd5, 16'h0000);
      send_request(CMD_INSERT, 10'd1023, 16'hffff);
      send_request(CMD_INSERT, 10'd0, 16'h0000);
      send_request(CMD_INSERT, 10'd0, 16'h1234);
      send_request(CMD_REDUCE, 10'd0, 16'h0);
      send_request(CMD_REDUCE, 10'd1023, 16'h0);
      send_request(CMD_REDUCE, 10'd77, 16'h0);
      send_request(CMD_INSERT, 10'd600, 16'haaaa);
      send_request(CMD_INSERT, 10'd300, 16'h5555);
      send_request(CMD_REDUCE, 10'd600, 16'h0);
      send_request(CMD_LOOKUP, 10'd511, 16'h0);
      send_request(CMD_LOOKUP, 10'd1000, 16'h0);
      send_request(CMD_REMOVE, 10'd0, 16'h0);
      send_request(CMD_REMOVE, 10'd0, 16'h0);
      send_request(CMD_REMOVE, 10'd0, 16'h0);
      send_request(CMD_REMOVE, 10'd0, 16'h0);
      send_request(CMD_REMOVE, 10'd0, 16'h0);

      write_csr(CSR_MAX_KEY, 10'd0);
      send_request(CMD_INSERT, 10'd1, 16'h0001);
      send_request(CMD_LOOKUP, 10'd1, 16'h0);
      send_request(CMD_INSERT, 10'd0, 16'hbeef);
      send_request(CMD_REMOVE, 10'd0, 16'h0);
      write_csr(CSR_CAPACITY, 10'd0);
      send_request(CMD_INSERT, 10'd0, 16'h0);
      write_csr(CSR_MAX_KEY, 10'd1023);

      write_csr(CSR_CAPACITY, 10'd3);
      random_run(120, 1023);
      write_csr(CSR_CAPACITY, 10'd1);
      random_run(40, 1023);
      write_csr(CSR_CAPACITY, 10'd511);
      write_csr(CSR_MAX_KEY, 10'd63);
      random_run(150, 63);
      drain();
      write_csr(CSR_MAX_KEY, 10'd1023);
      write_csr(CSR_CAPACITY, 10'd256);
      random_run(200, 1023);
      quiet = 1'b1;
      random_run(120, 1023);

      drain();
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule

// File: indexed_min_heap_decrease_key_top.f
hw/rtl/imhdk_pkg.sv
hw/rtl/imhdk_ctrl.sv
hw/rtl/imhdk_datapath.sv
hw/rtl/indexed_min_heap_decrease_key_top.sv
dv/tb.sv
